FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, skipped while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/core/swt_pkg.sv
package swt_pkg;

  localparam int ACTION_W  = 4;
  localparam int SEL_W     = 3;
  localparam int ELAPSED_W = 19;
  localparam int COUNT_W   = 4;
  localparam int DUR_W     = 17;

  localparam int LAP_DEPTH_DEF = 8;

  localparam logic [ELAPSED_W-1:0] SW_MAX     = 19'd359999;
  localparam logic [DUR_W-1:0]     TM_MAX     = 17'd86399;
  localparam logic [DUR_W-1:0]     TM_MIN     = 17'd1;
  localparam logic [DUR_W-1:0]     TM_RESET   = 17'd60;
  localparam logic [DUR_W-1:0]     WARN_LEVEL = 17'd10;
  localparam logic [DUR_W-1:0]     STEP_SMALL = 17'd10;
  localparam logic [DUR_W-1:0]     STEP_LARGE = 17'd60;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK      = 4'd0,
    ACT_SW_TOGGLE = 4'd1,
    ACT_LAP       = 4'd2,
    ACT_SW_RESET  = 4'd3,
    ACT_DUR_M60   = 4'd4,
    ACT_DUR_M10   = 4'd5,
    ACT_DUR_P10   = 4'd6,
    ACT_DUR_P60   = 4'd7,
    ACT_TM_TOGGLE = 4'd8,
    ACT_TM_RESET  = 4'd9
  } action_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] sw_elapsed;
    logic                 sw_active;
    logic [COUNT_W-1:0]   lap_count;
    logic [ELAPSED_W-1:0] lap_value;
    logic [DUR_W-1:0]     tm_duration;
    logic [DUR_W-1:0]     tm_remaining;
    logic                 tm_active;
    logic                 tm_done;
    logic                 tm_warning;
  } res_t;

endpackage

FILE: rtl/core/swt_lap_mem.sv
module swt_lap_mem #(
  parameter int DEPTH = swt_pkg::LAP_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [swt_pkg::ELAPSED_W-1:0]  wr_data,
  output logic [swt_pkg::ELAPSED_W-1:0]  rd_data
);
  import swt_pkg::*;

  logic [ELAPSED_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // write-first: a lap recorded on this same edge is seen by the read
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: rtl/core/swt_core.sv
`include "assert_macros.svh"

module swt_core #(
  parameter int LAP_DEPTH = swt_pkg::LAP_DEPTH_DEF,
  localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [swt_pkg::ACTION_W-1:0]  action,
  input  logic [swt_pkg::SEL_W-1:0]     sel,
  input  logic [swt_pkg::ELAPSED_W-1:0] lap_rdata,
  output swt_pkg::res_t                 res,
  output logic                          lap_we,
  output logic [AW-1:0]                 lap_waddr,
  output logic [swt_pkg::ELAPSED_W-1:0] lap_wdata
);
  import swt_pkg::*;

  localparam int CW   = $clog2(LAP_DEPTH + 1);
  localparam int SELW = (CW > SEL_W) ? CW : SEL_W;

  logic                 sw_run, sw_run_next;
  logic [ELAPSED_W-1:0] sw_elapsed, sw_elapsed_next;
  logic [CW-1:0]        laps, laps_next;
  logic [DUR_W-1:0]     tm_duration, tm_duration_next;
  logic [DUR_W-1:0]     tm_remaining, tm_remaining_next;
  logic                 tm_run, tm_run_next;
  logic                 tm_done, tm_done_next;

  logic [DUR_W:0]       dur_sum;
  logic [DUR_W-1:0]     dur_step;
  logic                 dur_up;
  logic [DUR_W-1:0]     rem_dec;
  logic                 lap_rec;
  logic [SELW-1:0]      sel_ext, laps_ext, wr_ext;
  logic                 hit_self;
  logic [CW+3:0]        cnt_wide;

  always_comb begin
    dur_step = (action == ACT_DUR_M60 || action == ACT_DUR_P60) ? STEP_LARGE : STEP_SMALL;
    dur_up   = (action == ACT_DUR_P10 || action == ACT_DUR_P60);
    dur_sum  = {1'b0, tm_duration} + {1'b0, dur_step};
    rem_dec  = (tm_remaining != '0) ? tm_remaining - 17'd1 : tm_remaining;

    sw_run_next       = sw_run;
    sw_elapsed_next   = sw_elapsed;
    laps_next         = laps;
    tm_duration_next  = tm_duration;
    tm_remaining_next = tm_remaining;
    tm_run_next       = tm_run;
    tm_done_next      = tm_done;
    lap_rec           = 1'b0;

    case (action)
      ACT_TICK: begin
        if (sw_run && (sw_elapsed < SW_MAX)) begin
          sw_elapsed_next = sw_elapsed + 19'd1;
        end
        if (tm_run) begin
          tm_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            tm_run_next  = 1'b0;
            tm_done_next = 1'b1;
          end
        end
      end
      ACT_SW_TOGGLE: begin
        sw_run_next = !sw_run;
      end
      ACT_LAP: begin
        if (sw_run && (laps < CW'(LAP_DEPTH))) begin
          lap_rec   = 1'b1;
          laps_next = laps + CW'(1);
        end
      end
      ACT_SW_RESET: begin
        sw_run_next     = 1'b0;
        sw_elapsed_next = '0;
        laps_next       = '0;
      end
      ACT_DUR_M60, ACT_DUR_M10, ACT_DUR_P10, ACT_DUR_P60: begin
        // duration is locked while counting or done
        if (!(tm_run || tm_done)) begin
          if (dur_up) begin
            tm_duration_next = (dur_sum > {1'b0, TM_MAX}) ? TM_MAX : dur_sum[DUR_W-1:0];
          end else begin
            tm_duration_next = (tm_duration <= dur_step) ? TM_MIN : tm_duration - dur_step;
          end
          tm_remaining_next = tm_duration_next;
        end
      end
      ACT_TM_TOGGLE: begin
        if (tm_done) begin
          tm_done_next      = 1'b0;
          tm_remaining_next = tm_duration;
          tm_run_next       = 1'b1;
        end else begin
          tm_run_next = !tm_run;
        end
      end
      ACT_TM_RESET: begin
        tm_run_next       = 1'b0;
        tm_done_next      = 1'b0;
        tm_remaining_next = tm_duration;
      end
      default: ;
    endcase
  end

  assign lap_we    = load && lap_rec;
  assign lap_waddr = laps[AW-1:0];
  assign lap_wdata = sw_elapsed;

  always_comb begin
    sel_ext  = SELW'(sel);
    laps_ext = SELW'(laps_next);
    wr_ext   = SELW'(laps);
    // lap recorded by this word at the selected slot bypasses the memory
    hit_self = lap_rec && (sel_ext == wr_ext);
    cnt_wide = {4'b0, laps_next};

    res.sw_elapsed   = sw_elapsed_next;
    res.sw_active    = sw_run_next;
    res.lap_count    = cnt_wide[COUNT_W-1:0];
    res.lap_value    = (sel_ext < laps_ext) ? (hit_self ? sw_elapsed : lap_rdata) : '0;
    res.tm_duration  = tm_duration_next;
    res.tm_remaining = tm_done_next ? '0 : tm_remaining_next;
    res.tm_active    = tm_run_next;
    res.tm_done      = tm_done_next;
    res.tm_warning   = tm_run_next && (tm_remaining_next <= WARN_LEVEL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_run       <= 1'b0;
      sw_elapsed   <= '0;
      laps         <= '0;
      tm_duration  <= TM_RESET;
      tm_remaining <= TM_RESET;
      tm_run       <= 1'b0;
      tm_done      <= 1'b0;
    end else if (load) begin
      sw_run       <= sw_run_next;
      sw_elapsed   <= sw_elapsed_next;
      laps         <= laps_next;
      tm_duration  <= tm_duration_next;
      tm_remaining <= tm_remaining_next;
      tm_run       <= tm_run_next;
      tm_done      <= tm_done_next;
    end
  end

  `ASSERT_CLK(a_done_not_running, clk, rst, !(tm_done && tm_run), "timer done while running")
  `ASSERT_CLK(a_dur, clk, rst, (tm_duration >= TM_MIN) && (tm_duration <= TM_MAX), "duration range")
  `ASSERT_CLK(a_laps_bound, clk, rst, laps <= CW'(LAP_DEPTH), "lap count beyond store depth")
  `ASSERT_CLK(a_sw_sat, clk, rst, sw_elapsed <= SW_MAX, "stopwatch past saturation")
  `ASSERT_CLK(a_hold, clk, rst, !load |=> $stable({sw_elapsed, laps, tm_remaining}), "state moved")

endmodule

FILE: rtl/core/stopwatch_countdown_timer.sv
// Stopwatch with laps and countdown timer, one action word per cycle unless
// out_ready stalls the output; a word is held in the input register, then its
// result passes through one logic stage into the result register.
// Lap memory has one registered read port, addressed by lap_index at accept.
// Reset (rst, synchronous) clears counters, flags and handshake; timer loads 60 s.
// Lap memory is not cleared; only recorded entries are ever reported.
module stopwatch_countdown_timer #(
  parameter int LAP_DEPTH = swt_pkg::LAP_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swt_pkg::ACTION_W-1:0]  action,
  input  logic [swt_pkg::SEL_W-1:0]     lap_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swt_pkg::ELAPSED_W-1:0] sw_elapsed,
  output logic                          sw_active,
  output logic [swt_pkg::COUNT_W-1:0]   lap_count,
  output logic [swt_pkg::ELAPSED_W-1:0] lap_value,
  output logic [swt_pkg::DUR_W-1:0]     tm_duration,
  output logic [swt_pkg::DUR_W-1:0]     tm_remaining,
  output logic                          tm_active,
  output logic                          tm_done,
  output logic                          tm_warning
);
  import swt_pkg::*;

  localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;

  logic                 s1_valid;
  logic [ACTION_W-1:0]  s1_action;
  logic [SEL_W-1:0]     s1_sel;
  logic                 load;
  logic                 accept;
  res_t                 res_next;
  res_t                 res;
  logic                 lap_we;
  logic [AW-1:0]        lap_waddr;
  logic [ELAPSED_W-1:0] lap_wdata;
  logic [ELAPSED_W-1:0] lap_rdata;
  logic [AW+SEL_W-1:0]  sel_wide;

  assign load     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || load;
  assign accept   = in_valid && in_ready;
  assign sel_wide = {AW'(0), lap_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= action;
      s1_sel    <= lap_index;
    end
  end

  swt_lap_mem #(
    .DEPTH(LAP_DEPTH)
  ) u_lap_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (sel_wide[AW-1:0]),
    .wr_en   (lap_we),
    .wr_addr (lap_waddr),
    .wr_data (lap_wdata),
    .rd_data (lap_rdata)
  );

  swt_core #(
    .LAP_DEPTH(LAP_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .action    (s1_action),
    .sel       (s1_sel),
    .lap_rdata (lap_rdata),
    .res       (res_next),
    .lap_we    (lap_we),
    .lap_waddr (lap_waddr),
    .lap_wdata (lap_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  assign sw_elapsed   = res.sw_elapsed;
  assign sw_active    = res.sw_active;
  assign lap_count    = res.lap_count;
  assign lap_value    = res.lap_value;
  assign tm_duration  = res.tm_duration;
  assign tm_remaining = res.tm_remaining;
  assign tm_active    = res.tm_active;
  assign tm_done      = res.tm_done;
  assign tm_warning   = res.tm_warning;

endmodule

FILE: tb/sv/swt_checker.sv
module swt_checker #(
  parameter int LAP_DEPTH = swt_pkg::LAP_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [swt_pkg::ACTION_W-1:0]  action,
  input  logic [swt_pkg::SEL_W-1:0]     lap_index,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [swt_pkg::ELAPSED_W-1:0] sw_elapsed,
  input  logic                          sw_active,
  input  logic [swt_pkg::COUNT_W-1:0]   lap_count,
  input  logic [swt_pkg::ELAPSED_W-1:0] lap_value,
  input  logic [swt_pkg::DUR_W-1:0]     tm_duration,
  input  logic [swt_pkg::DUR_W-1:0]     tm_remaining,
  input  logic                          tm_active,
  input  logic                          tm_done,
  input  logic                          tm_warning,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import swt_pkg::*;

  localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;

  // predicted block state
  logic                 sw_on;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] lap_mem [LAP_DEPTH];
  logic [COUNT_W-1:0]   laps_held;
  logic [DUR_W-1:0]     duration;
  logic [DUR_W-1:0]     remaining;
  logic                 tm_on;
  logic                 tm_fired;

  res_t status_q[$];

  task automatic report(input string msg);
    errors++;
    $display("%0t: %s", $realtime, msg);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // duration edits only land while the timer is paused and not done
  task automatic nudge_duration(input logic up, input logic [DUR_W-1:0] amount);
    if (!tm_on && !tm_fired) begin
      if (up)
        duration = (int'(duration) + int'(amount) > int'(TM_MAX)) ? TM_MAX : duration + amount;
      else
        duration = (duration <= amount) ? TM_MIN : duration - amount;
      remaining = duration;
    end
  endtask

  task automatic apply_word(input logic [ACTION_W-1:0] act, input logic [SEL_W-1:0] sel,
                            output res_t st);
    case (act)
      ACT_TICK: begin
        if (sw_on && elapsed < SW_MAX) elapsed++;
        if (tm_on) begin
          if (remaining != '0) remaining--;
          if (remaining == '0) begin
            tm_on    = 1'b0;
            tm_fired = 1'b1;
          end
        end
      end
      ACT_SW_TOGGLE: sw_on = !sw_on;
      ACT_LAP: begin
        if (sw_on && laps_held < LAP_DEPTH) begin
          lap_mem[laps_held[AW-1:0]] = elapsed;
          laps_held++;
        end
      end
      ACT_SW_RESET: begin
        sw_on     = 1'b0;
        elapsed   = '0;
        laps_held = '0;
      end
      ACT_DUR_M60: nudge_duration(1'b0, STEP_LARGE);
      ACT_DUR_M10: nudge_duration(1'b0, STEP_SMALL);
      ACT_DUR_P10: nudge_duration(1'b1, STEP_SMALL);
      ACT_DUR_P60: nudge_duration(1'b1, STEP_LARGE);
      ACT_TM_TOGGLE: begin
        if (tm_fired) begin
          tm_fired  = 1'b0;
          remaining = duration;
          tm_on     = 1'b1;
        end else begin
          tm_on = !tm_on;
        end
      end
      ACT_TM_RESET: begin
        tm_on     = 1'b0;
        tm_fired  = 1'b0;
        remaining = duration;
      end
      default: ;
    endcase
    st.sw_elapsed   = elapsed;
    st.sw_active    = sw_on;
    st.lap_count    = laps_held;
    st.lap_value    = (COUNT_W'(sel) < laps_held) ? lap_mem[sel] : '0;
    st.tm_duration  = duration;
    st.tm_remaining = tm_fired ? '0 : remaining;
    st.tm_active    = tm_on;
    st.tm_done      = tm_fired;
    st.tm_warning   = tm_on && (remaining <= WARN_LEVEL);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      sw_on     = 1'b0;
      elapsed   = '0;
      laps_held = '0;
      duration  = TM_RESET;
      remaining = TM_RESET;
      tm_on     = 1'b0;
      tm_fired  = 1'b0;
      status_q.delete();
    end else begin
      // result side first: the word leaving now was accepted at an earlier edge
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          report("result word with nothing due");
        end else begin
          want = status_q.pop_front();
          cmp_field("sw_elapsed", 32'(sw_elapsed), 32'(want.sw_elapsed));
          cmp_field("sw_active", 32'(sw_active), 32'(want.sw_active));
          cmp_field("lap_count", 32'(lap_count), 32'(want.lap_count));
          cmp_field("lap_value", 32'(lap_value), 32'(want.lap_value));
          cmp_field("tm_duration", 32'(tm_duration), 32'(want.tm_duration));
          cmp_field("tm_remaining", 32'(tm_remaining), 32'(want.tm_remaining));
          cmp_field("tm_active", 32'(tm_active), 32'(want.tm_active));
          cmp_field("tm_done", 32'(tm_done), 32'(want.tm_done));
          cmp_field("tm_warning", 32'(tm_warning), 32'(want.tm_warning));
        end
      end
      if (in_valid && in_ready) begin
        apply_word(action, lap_index, want);
        status_q.push_back(want);
      end
    end
    pending = status_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swt_pkg::*;

  localparam int     RANDOM_WORDS = 1550;
  localparam int     COUNT_TICKS  = 100;
  localparam int     HOLD_AT      = 6;
  localparam int     HOLD_CYCLES  = 80;
  localparam longint CYCLE_LIMIT  = 40000;

  // codes the block treats as no-ops
  localparam logic [ACTION_W-1:0] ACT_NOP_A = 4'd10;
  localparam logic [ACTION_W-1:0] ACT_NOP_F = 4'd15;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [ACTION_W-1:0]  action;
  logic [SEL_W-1:0]     lap_index;
  logic                 out_valid;
  logic                 out_ready;
  logic [ELAPSED_W-1:0] sw_elapsed;
  logic                 sw_active;
  logic [COUNT_W-1:0]   lap_count;
  logic [ELAPSED_W-1:0] lap_value;
  logic [DUR_W-1:0]     tm_duration;
  logic [DUR_W-1:0]     tm_remaining;
  logic                 tm_active;
  logic                 tm_done;
  logic                 tm_warning;

  int     errors;
  int     pending;
  int     words_sent;
  longint cycles;
  bit     calm;

  stopwatch_countdown_timer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .lap_index    (lap_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sw_elapsed   (sw_elapsed),
    .sw_active    (sw_active),
    .lap_count    (lap_count),
    .lap_value    (lap_value),
    .tm_duration  (tm_duration),
    .tm_remaining (tm_remaining),
    .tm_active    (tm_active),
    .tm_done      (tm_done),
    .tm_warning   (tm_warning)
  );

  swt_checker chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .lap_index    (lap_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sw_elapsed   (sw_elapsed),
    .sw_active    (sw_active),
    .lap_count    (lap_count),
    .lap_value    (lap_value),
    .tm_duration  (tm_duration),
    .tm_remaining (tm_remaining),
    .tm_active    (tm_active),
    .tm_done      (tm_done),
    .tm_warning   (tm_warning),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off early on so the block backs up
  initial begin
    int  hold;
    bit  held;
    hold      = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && words_sent >= HOLD_AT) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = calm || ($urandom_range(99) >= 36);
      end
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [SEL_W-1:0] sel);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    action    = act;
    lap_index = sel;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  initial begin
    int                  r;
    logic [ACTION_W-1:0] act;
    words_sent = 0;
    calm       = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    action     = '0;
    lap_index  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed; lap_index stays 0 until the lap store has been filled once
    send_word(ACT_NOP_F, 3'd0);
    send_word(ACT_LAP, 3'd0);        // paused, ignored
    send_word(ACT_SW_TOGGLE, 3'd0);
    send_word(ACT_TICK, 3'd0);
    for (int k = 0; k < 8; k++) begin
      send_word(ACT_LAP, 3'd0);
      if (k % 3 == 0) send_word(ACT_TICK, 3'd0);
    end
    send_word(ACT_LAP, 3'd7);        // store full
    send_word(ACT_SW_TOGGLE, 3'd3);
    send_word(ACT_TICK, 3'd6);       // paused tick holds
    send_word(ACT_SW_RESET, 3'd5);   // entry written but no longer recorded
    send_word(ACT_DUR_M60, 3'd2);    // clamps to the minimum
    send_word(ACT_DUR_M10, 3'd1);
    send_word(ACT_DUR_P10, 3'd4);
    send_word(ACT_TM_TOGGLE, 3'd0);
    send_word(ACT_DUR_P60, 3'd0);    // running, ignored
    send_word(ACT_TM_TOGGLE, 3'd7);  // pause keeps remaining
    send_word(ACT_TM_RESET, 3'd0);
    send_word(ACT_NOP_A, 3'd7);

    // back-to-back run: full countdown to done, restart, pause and resume
    calm = 1'b1;
    send_word(ACT_SW_TOGGLE, 3'd0);
    send_word(ACT_DUR_P60, 3'd0);
    send_word(ACT_TM_TOGGLE, 3'd0);
    for (int k = 0; k < COUNT_TICKS; k++) send_word(ACT_TICK, SEL_W'($urandom_range(7)));
    send_word(ACT_LAP, 3'd0);
    send_word(ACT_DUR_P10, 3'd0);    // done, ignored
    send_word(ACT_TM_TOGGLE, 3'd0);  // restart after done
    send_word(ACT_DUR_M60, 3'd0);
    send_word(ACT_TM_TOGGLE, 3'd0);
    send_word(ACT_TICK, 3'd0);
    send_word(ACT_TM_TOGGLE, 3'd0);
    send_word(ACT_TICK, 3'd0);
    send_word(ACT_SW_RESET, 3'd0);
    send_word(ACT_TM_RESET, 3'd0);
    calm = 1'b0;

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      r = $urandom_range(99);
      if (r < 45)      act = ACT_TICK;
      else if (r < 52) act = ACT_SW_TOGGLE;
      else if (r < 62) act = ACT_LAP;
      else if (r < 64) act = ACT_SW_RESET;
      else if (r < 80) act = ACTION_W'($urandom_range(ACT_DUR_P60, ACT_DUR_M60));
      else if (r < 90) act = ACT_TM_TOGGLE;
      else if (r < 93) act = ACT_TM_RESET;
      else             act = ACTION_W'($urandom_range(ACT_NOP_F, ACT_NOP_A));
      send_word(act, SEL_W'($urandom_range(7)));
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
